FILE: src/abbg_pkg.sv
// shared types, codes and constants for the arcade board bus glue
package abbg_pkg;

   localparam int TILE_RAM_DEPTH = 1024;
   localparam int CSR_INDEX_W    = 1;

   // bus access kinds
   typedef enum logic [1:0] {
      ACT_MAIN_RD = 2'd0,
      ACT_MAIN_WR = 2'd1,
      ACT_SND_RD  = 2'd2,
      ACT_SND_WR  = 2'd3
   } action_type;

   // sound-side chip targets
   typedef enum logic [1:0] {
      CHIP_NONE = 2'd0,
      CHIP_AY0  = 2'd1,
      CHIP_AY1  = 2'd2,
      CHIP_DAC  = 2'd3
   } chip_type;

   // where the read byte of a beat comes from
   typedef enum logic [1:0] {
      RD_SRC_REG    = 2'd0,
      RD_SRC_VIDEO  = 2'd1,
      RD_SRC_COLOUR = 2'd2
   } rd_src_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_A = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_B = 1'd1;

   localparam logic [7:0] DIP_A_RESET = 8'd15;
   localparam logic [7:0] DIP_B_RESET = 8'd1;

   localparam logic [15:0] WIN_MASK        = 16'hfc00;
   localparam logic [15:0] WIN_VIDEO_SWAP  = 16'h4000;
   localparam logic [15:0] WIN_COLOUR_SWAP = 16'h4400;
   localparam logic [15:0] WIN_VIDEO_FLAT  = 16'h4800;
   localparam logic [15:0] WIN_COLOUR_FLAT = 16'h4c00;

   localparam logic [15:0] ADDR_2000 = 16'h2000;
   localparam logic [15:0] ADDR_2001 = 16'h2001;
   localparam logic [15:0] ADDR_2002 = 16'h2002;
   localparam logic [15:0] ADDR_2003 = 16'h2003;
   localparam logic [15:0] ADDR_2004 = 16'h2004;
   localparam logic [15:0] ADDR_2005 = 16'h2005;
   localparam logic [15:0] ADDR_2007 = 16'h2007;

   localparam logic [7:0] DIP_A_MASK = 8'h7f;
   localparam logic [7:0] VBLANK_BIT = 8'h80;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  port_a_lines;
      logic [7:0]  port_b_lines;
      logic        vblank;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       sound_irq_raise;
      logic       main_irq_clear;
      logic [1:0] chip_write;
      logic       chip_port;
      logic [7:0] chip_data;
      logic [7:0] flip_screen;
      logic [1:0] palette_select;
      logic [7:0] sound_nmi_enable;
   } rsp_type;

endpackage

FILE: src/arcade_board_bus_glue_top.sv
// top level of the arcade board bus glue: decode, control registers and tile rams
// a beat goes through the input and result stages; its result shows for one cycle
// throughput: one beat per cycle while busy is low (single-port rams, one access each)
// reset: synchronous, active high; registers return to reset values, then a clearing
//   pass over all TILE_RAM_DEPTH (1024) entries zeroes both tile rams with busy held high
// the receiver cannot stall, so results are strobed out and never held
module arcade_board_bus_glue_top #(
   parameter int TILE_RAM_DEPTH = abbg_pkg::TILE_RAM_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request side
   input  logic                                start,
   output logic                                busy,
   input  abbg_pkg::req_type                   req_data,
   // response side
   output logic                                rsp_valid,
   output abbg_pkg::rsp_type                   rsp_data,
   // configuration
   input  logic                                csr_we,
   input  logic [abbg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                          csr_wdata
);

   localparam int IDX_W = $clog2(TILE_RAM_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE_RAM_DEPTH - 1);

   // clearing pass state
   logic             clr_active_ff, clr_active_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;

   // input stage
   logic              item_valid_ff;
   abbg_pkg::req_type item_ff;

   // architectural registers
   logic [7:0] dip_a_ff, dip_a_in;
   logic [7:0] dip_b_ff, dip_b_in;
   logic [7:0] flip_ff, flip_in;
   logic [1:0] bank_ff, bank_in;
   logic [7:0] latch_ff, latch_in;
   logic [7:0] nmi_ff, nmi_in;

   // result stage
   logic                   rsp_valid_ff;
   abbg_pkg::rd_src_type   rd_src_ff, rd_src_in;
   logic [7:0]             rd_ff, rd_in;
   logic                   irq_raise_ff, irq_raise_in;
   logic                   irq_clear_ff, irq_clear_in;
   abbg_pkg::chip_type     chip_ff, chip_in;
   logic                   port_ff, port_in;
   logic [7:0]             cdata_ff, cdata_in;

   // decode signals
   abbg_pkg::action_type act;
   logic [15:0]          addr;
   logic [15:0]          win;
   logic                 sel_video, sel_colour;
   logic [IDX_W-1:0]     tile_idx;
   logic                 main_wr;

   // ram ports
   logic             vram_we, cram_we;
   logic [IDX_W-1:0] ram_addr;
   logic [7:0]       ram_wdata;
   logic [7:0]       vram_rdata, cram_rdata;

   assign busy = clr_active_ff;

   assign act  = abbg_pkg::action_type'(item_ff.action);
   assign addr = item_ff.address;
   assign win  = addr & abbg_pkg::WIN_MASK;

   // swapped windows trade the 5-bit row and column fields of the offset
   always_comb begin
      sel_video  = 1'b0;
      sel_colour = 1'b0;
      tile_idx   = addr[IDX_W-1:0];
      if (win == abbg_pkg::WIN_VIDEO_SWAP) begin
         sel_video = 1'b1;
         tile_idx  = IDX_W'({addr[4:0], addr[9:5]});
      end else if (win == abbg_pkg::WIN_COLOUR_SWAP) begin
         sel_colour = 1'b1;
         tile_idx   = IDX_W'({addr[4:0], addr[9:5]});
      end else if (win == abbg_pkg::WIN_VIDEO_FLAT) begin
         sel_video = 1'b1;
      end else if (win == abbg_pkg::WIN_COLOUR_FLAT) begin
         sel_colour = 1'b1;
      end
   end

   assign main_wr = item_valid_ff && (act == abbg_pkg::ACT_MAIN_WR);

   // clearing pass owns the ram port until done; no beat is in flight then
   assign ram_addr  = clr_active_ff ? clr_cnt_ff : tile_idx;
   assign ram_wdata = clr_active_ff ? 8'd0 : item_ff.write_data;
   assign vram_we   = clr_active_ff || (main_wr && sel_video);
   assign cram_we   = clr_active_ff || (main_wr && sel_colour);

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_IDX) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // config writes
   always_comb begin
      dip_a_in = dip_a_ff;
      dip_b_in = dip_b_ff;
      if (csr_we) begin
         case (csr_index)
            abbg_pkg::CSR_DIP_A: begin
               dip_a_in = csr_wdata;
            end
            abbg_pkg::CSR_DIP_B: begin
               dip_b_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // register decode and result fields for the beat in the input stage
   always_comb begin
      flip_in      = flip_ff;
      bank_in      = bank_ff;
      latch_in     = latch_ff;
      nmi_in       = nmi_ff;
      rd_src_in    = abbg_pkg::RD_SRC_REG;
      rd_in        = 8'd0;
      irq_raise_in = 1'b0;
      irq_clear_in = 1'b0;
      chip_in      = abbg_pkg::CHIP_NONE;
      port_in      = 1'b0;
      cdata_in     = 8'd0;
      if (item_valid_ff) begin
         case (act)
            abbg_pkg::ACT_MAIN_RD: begin
               if (sel_video) begin
                  rd_src_in = abbg_pkg::RD_SRC_VIDEO;
               end else if (sel_colour) begin
                  rd_src_in = abbg_pkg::RD_SRC_COLOUR;
               end else if (addr == abbg_pkg::ADDR_2000) begin
                  rd_in = item_ff.port_b_lines;
               end else if (addr == abbg_pkg::ADDR_2001) begin
                  rd_in = item_ff.port_a_lines;
               end else if (addr == abbg_pkg::ADDR_2002) begin
                  rd_in = (dip_a_ff & abbg_pkg::DIP_A_MASK)
                        | (item_ff.vblank ? abbg_pkg::VBLANK_BIT : 8'd0);
               end else if (addr == abbg_pkg::ADDR_2003) begin
                  rd_in = dip_b_ff;
               end
            end
            abbg_pkg::ACT_MAIN_WR: begin
               // tile windows never overlap the register page
               if (addr == abbg_pkg::ADDR_2000) begin
                  flip_in = item_ff.write_data;
               end else if (addr == abbg_pkg::ADDR_2001) begin
                  bank_in = {item_ff.write_data[7], 1'b0};
               end else if (addr == abbg_pkg::ADDR_2002) begin
                  latch_in     = item_ff.write_data;
                  irq_raise_in = 1'b1;
               end else if (addr == abbg_pkg::ADDR_2003) begin
                  irq_clear_in = 1'b1;
               end
            end
            abbg_pkg::ACT_SND_RD: begin
               if (addr == abbg_pkg::ADDR_2007) begin
                  rd_in = latch_ff;
               end
            end
            abbg_pkg::ACT_SND_WR: begin
               if (addr == abbg_pkg::ADDR_2000 || addr == abbg_pkg::ADDR_2001) begin
                  chip_in  = abbg_pkg::CHIP_AY0;
                  port_in  = ~addr[0];
                  cdata_in = item_ff.write_data;
               end else if (addr == abbg_pkg::ADDR_2002 || addr == abbg_pkg::ADDR_2003) begin
                  chip_in  = abbg_pkg::CHIP_AY1;
                  port_in  = ~addr[0];
                  cdata_in = item_ff.write_data;
               end else if (addr == abbg_pkg::ADDR_2004) begin
                  chip_in  = abbg_pkg::CHIP_DAC;
                  cdata_in = item_ff.write_data;
               end else if (addr == abbg_pkg::ADDR_2005) begin
                  nmi_in = item_ff.write_data;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dip_a_ff      <= abbg_pkg::DIP_A_RESET;
         dip_b_ff      <= abbg_pkg::DIP_B_RESET;
         flip_ff       <= 8'd0;
         bank_ff       <= 2'd0;
         latch_ff      <= 8'd0;
         nmi_ff        <= 8'd0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         item_valid_ff <= start && !busy;
         rsp_valid_ff  <= item_valid_ff;
         dip_a_ff      <= dip_a_in;
         dip_b_ff      <= dip_b_in;
         flip_ff       <= flip_in;
         bank_ff       <= bank_in;
         latch_ff      <= latch_in;
         nmi_ff        <= nmi_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         item_ff <= req_data;
      end
      rd_src_ff    <= rd_src_in;
      rd_ff        <= rd_in;
      irq_raise_ff <= irq_raise_in;
      irq_clear_ff <= irq_clear_in;
      chip_ff      <= chip_in;
      port_ff      <= port_in;
      cdata_ff     <= cdata_in;
   end

   abbg_tile_ram #(
      .DEPTH (TILE_RAM_DEPTH)
   ) u_video_ram (
      .clock (clock),
      .we    (vram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (vram_rdata)
   );

   abbg_tile_ram #(
      .DEPTH (TILE_RAM_DEPTH)
   ) u_colour_ram (
      .clock (clock),
      .we    (cram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (cram_rdata)
   );

   // result beat: ram read data joins the registered fields here
   always_comb begin
      case (rd_src_ff)
         abbg_pkg::RD_SRC_VIDEO: begin
            rsp_data.read_data = vram_rdata;
         end
         abbg_pkg::RD_SRC_COLOUR: begin
            rsp_data.read_data = cram_rdata;
         end
         default: begin
            rsp_data.read_data = rd_ff;
         end
      endcase
      rsp_data.sound_irq_raise  = irq_raise_ff;
      rsp_data.main_irq_clear   = irq_clear_ff;
      rsp_data.chip_write       = chip_ff;
      rsp_data.chip_port        = port_ff;
      rsp_data.chip_data        = cdata_ff;
      // control registers already hold their value after this beat
      rsp_data.flip_screen      = flip_ff;
      rsp_data.palette_select   = bank_ff;
      rsp_data.sound_nmi_enable = nmi_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/abbg_tile_ram.sv
// single-port tile ram with registered read data
module abbg_tile_ram #(
   parameter int DEPTH = abbg_pkg::TILE_RAM_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [7:0]               wdata,
   output logic [7:0]               rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
